/* sv/mstw_pkg.sv */
package mstw_pkg;

    localparam int MAX_NODES   = 32;
    localparam int WEIGHT_BITS = 8;

    localparam int VTX_FIELD_BITS = 5;
    localparam int WGT_FIELD_BITS = 8;
    localparam int CFG_BITS       = 6;
    localparam int SUM_BITS       = 13;

    localparam int VTX_BITS  = $clog2(MAX_NODES);
    localparam int CNT_BITS  = $clog2(MAX_NODES + 1);
    localparam int ADDR_BITS = 2 * VTX_BITS;

    localparam logic [CFG_BITS-1:0] NODE_COUNT_RESET = CFG_BITS'(32);
    localparam logic [SUM_BITS-1:0] SUM_MAX          = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MIRROR,
        S_RELAX,
        S_SELECT,
        S_FINISH
    } t_state;

endpackage

/* sv/mstw_if.sv */
interface mstw_edge_if import mstw_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [VTX_FIELD_BITS-1:0] row_vertex;
    logic [VTX_FIELD_BITS-1:0] col_vertex;
    logic [WGT_FIELD_BITS-1:0] edge_weight;
    logic                      last_edge;

    modport source (output valid, row_vertex, col_vertex, edge_weight, last_edge,
                    input ready);
    modport sink   (input valid, row_vertex, col_vertex, edge_weight, last_edge,
                    output ready);
endinterface

interface mstw_res_if import mstw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SUM_BITS-1:0] tree_weight;
    logic                disconnected;

    modport source (output valid, tree_weight, disconnected, input ready);
    modport sink   (input valid, tree_weight, disconnected, output ready);
endinterface

interface mstw_cfg_if import mstw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* sv/prim_mst_weight.sv */
// Minimum spanning tree weight by a Prim walk from vertex 0. After reset the
// block clears all 1024 entries of its 32x32 weight memory, one entry a cycle,
// before it takes the first edge word. Each edge word then gets one memory
// write for each of the two symmetric entries. A word marked last starts the
// walk over the first node_count vertices: every relax pass reads one memory
// row entry a cycle through the single read port, and every selection pass
// compares one key a cycle. The result word comes out of an output register;
// the block takes no edge word while a walk runs.
module prim_mst_weight import mstw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mstw_cfg_if.sink    i_cfg,
    mstw_edge_if.sink   i_edge,
    mstw_res_if.source  o_result
);

    logic [WEIGHT_BITS-1:0] mem [MAX_NODES*MAX_NODES];
    logic [WEIGHT_BITS-1:0] r_key [MAX_NODES];

    t_state                 r_state, n_state;
    logic [CFG_BITS-1:0]    r_node_count;
    logic [ADDR_BITS-1:0]   r_clr, n_clr;
    logic [VTX_BITS-1:0]    r_row, n_row;
    logic [VTX_BITS-1:0]    r_col, n_col;
    logic [WEIGHT_BITS-1:0] r_wgt, n_wgt;
    logic                   r_wr_ok, n_wr_ok;
    logic                   r_last, n_last;
    logic [CNT_BITS-1:0]    r_n, n_n;
    logic [CNT_BITS-1:0]    r_v, n_v;
    logic [CNT_BITS-1:0]    r_step, n_step;
    logic [VTX_BITS-1:0]    r_u, n_u;
    logic [MAX_NODES-1:0]   r_in_tree, n_in_tree;
    logic [MAX_NODES-1:0]   r_kv, n_kv;
    logic                   r_rd_vld, n_rd_vld;
    logic [VTX_BITS-1:0]    r_rd_idx, n_rd_idx;
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic                   r_found, n_found;
    logic [VTX_BITS-1:0]    r_pick, n_pick;
    logic [WEIGHT_BITS-1:0] r_best, n_best;
    logic [SUM_BITS-1:0]    r_sum, n_sum;
    logic                   r_disc, n_disc;
    logic                   r_out_valid, n_out_valid;
    logic [SUM_BITS-1:0]    r_out_sum, n_out_sum;
    logic                   r_out_disc, n_out_disc;

    logic                   mem_we;
    logic [ADDR_BITS-1:0]   mem_wa;
    logic [WEIGHT_BITS-1:0] mem_wd;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic                   key_we;
    logic [VTX_BITS-1:0]    key_wa;
    logic [WEIGHT_BITS-1:0] key_wd;
    logic                   edge_acc;
    logic [CNT_BITS-1:0]    n_eff;
    logic [VTX_BITS-1:0]    s_idx;
    logic                   upd, cand;
    logic [SUM_BITS:0]      sum_ext;

    assign i_cfg.ready  = 1'b1;
    assign i_edge.ready = (r_state == S_IDLE);
    assign edge_acc     = i_edge.valid && i_edge.ready;

    assign o_result.valid        = r_out_valid;
    assign o_result.tree_weight  = r_out_sum;
    assign o_result.disconnected = r_out_disc;

    // effective vertex count: zero counts as one, large values saturate
    assign n_eff = (r_node_count == '0) ? CNT_BITS'(1) :
                   (32'(r_node_count) > MAX_NODES) ? CNT_BITS'(MAX_NODES) :
                   CNT_BITS'(r_node_count);

    assign s_idx = r_v[VTX_BITS-1:0];
    assign upd   = r_rd_vld && !r_in_tree[r_rd_idx] && (r_rd_data != '0) &&
                   (!r_kv[r_rd_idx] || (r_rd_data < r_key[r_rd_idx]));
    assign cand  = (r_v < r_n) && !r_in_tree[s_idx] && r_kv[s_idx] &&
                   (!r_found || (r_key[s_idx] < r_best));
    assign sum_ext = {1'b0, r_sum} + (SUM_BITS+1)'(r_best);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_row       = r_row;
        n_col       = r_col;
        n_wgt       = r_wgt;
        n_wr_ok     = r_wr_ok;
        n_last      = r_last;
        n_n         = r_n;
        n_v         = r_v;
        n_step      = r_step;
        n_u         = r_u;
        n_in_tree   = r_in_tree;
        n_kv        = r_kv;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_pick      = r_pick;
        n_best      = r_best;
        n_sum       = r_sum;
        n_disc      = r_disc;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_sum   = r_out_sum;
        n_out_disc  = r_out_disc;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        rd_addr     = {r_u, s_idx};
        key_we      = 1'b0;
        key_wa      = r_rd_idx;
        key_wd      = r_rd_data;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (edge_acc) begin
                    n_row   = VTX_BITS'(i_edge.row_vertex);
                    n_col   = VTX_BITS'(i_edge.col_vertex);
                    n_wgt   = WEIGHT_BITS'(i_edge.edge_weight);
                    n_last  = i_edge.last_edge;
                    n_wr_ok = (32'(i_edge.row_vertex) < MAX_NODES) &&
                              (32'(i_edge.col_vertex) < MAX_NODES);
                    mem_we  = n_wr_ok;
                    mem_wa  = {n_row, n_col};
                    mem_wd  = n_wgt;
                    n_state = S_MIRROR;
                end
            end
            S_MIRROR: begin
                mem_we = r_wr_ok;
                mem_wa = {r_col, r_row};
                mem_wd = r_wgt;
                if (r_last) begin
                    n_n       = n_eff;
                    n_v       = '0;
                    n_step    = CNT_BITS'(1);
                    n_u       = '0;
                    n_in_tree = MAX_NODES'(1);
                    n_kv      = '0;
                    n_sum     = '0;
                    n_state   = S_RELAX;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RELAX: begin
                // issue reads of row u, update keys in the cycle after each read
                if (r_v < r_n) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = s_idx;
                    n_v      = r_v + 1'b1;
                end
                if (upd) begin
                    key_we         = 1'b1;
                    n_kv[r_rd_idx] = 1'b1;
                end
                if ((r_v == r_n) && !r_rd_vld) begin
                    n_v     = '0;
                    n_found = 1'b0;
                    if (r_step == r_n) begin
                        n_disc  = 1'b0;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SELECT;
                    end
                end
            end
            S_SELECT: begin
                if (r_v < r_n) begin
                    if (cand) begin
                        n_found = 1'b1;
                        n_pick  = s_idx;
                        n_best  = r_key[s_idx];
                    end
                    n_v = r_v + 1'b1;
                end else if (!r_found) begin
                    n_disc  = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    n_in_tree[r_pick] = 1'b1;
                    n_sum   = (sum_ext > (SUM_BITS+1)'(SUM_MAX)) ? SUM_MAX :
                              sum_ext[SUM_BITS-1:0];
                    n_u     = r_pick;
                    n_step  = r_step + 1'b1;
                    n_v     = '0;
                    n_state = S_RELAX;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_sum;
                    n_out_disc  = r_disc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_node_count <= NODE_COUNT_RESET;
            r_in_tree    <= '0;
            r_kv         <= '0;
            r_rd_vld     <= 1'b0;
            r_step       <= '0;
            r_n          <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_in_tree   <= n_in_tree;
            r_kv        <= n_kv;
            r_rd_vld    <= n_rd_vld;
            r_step      <= n_step;
            r_n         <= n_n;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_node_count <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_wgt      <= n_wgt;
        r_wr_ok    <= n_wr_ok;
        r_last     <= n_last;
        r_v        <= n_v;
        r_u        <= n_u;
        r_rd_idx   <= n_rd_idx;
        r_found    <= n_found;
        r_pick     <= n_pick;
        r_best     <= n_best;
        r_disc     <= n_disc;
        r_out_sum  <= n_out_sum;
        r_out_disc <= n_out_disc;
    end

    // weight memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[key_wa] <= key_wd;
        end
    end

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result word raised outside finish");

    a_tree_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELAX || r_state == S_SELECT) |->
            ($countones(r_in_tree) == 32'(r_step)))
        else $error("tree size and step count differ");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELAX || r_state == S_SELECT) |->
            (r_step <= r_n && r_in_tree[0]))
        else $error("walk step beyond vertex count");

endmodule
